// ----- design/bfs_pkg.sv -----
`default_nettype none
package bfs_pkg;
    localparam int VW = 6;
    localparam int DEF_NUM_VERTICES = 64;
    localparam int DEF_MAX_EDGES = 256;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_BFS   = 2'd2;
    localparam logic [1:0] CMD_PATH  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOPATH = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]    command;
        logic [VW-1:0] first_vertex;
        logic [VW-1:0] second_vertex;
    } bfs_in_t;

    typedef struct packed {
        logic [VW-1:0] vertex;
        logic [VW-1:0] distance;
        logic [1:0]    status;
        logic          last;
    } bfs_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load_cmd;      // capture command fields
        logic clear_marks;   // clear visit marks and queue
        logic add_edge;      // write edge at count
        logic clear_graph;   // zero edge count, clear visit marks and queue
        logic seed_root;     // mark root, enqueue it
        logic pop;           // read queue head
        logic scan_start;    // latch popped distance, advance head, reset edge index
        logic scan_read;     // issue edge read
        logic scan_visit;    // evaluate edge read data
        logic emit_bfs;      // emit popped vertex
        logic path_init;     // start walk at end vertex
        logic path_step;     // emit current and advance
        logic emit_full;
        logic emit_nopath_end;
    } bfs_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic edge_ok;       // both endpoints in range
        logic store_full;
        logic root_ok;
        logic queue_empty;
        logic scan_done;
        logic end_ok;        // end in range and visited
        logic path_final;    // current vertex is start or root
    } bfs_sts_t;
endpackage
`default_nettype wire

// ----- design/bfs_ram.sv -----
`default_nettype none
module bfs_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- design/bfs_datapath.sv -----
`default_nettype none
module bfs_datapath
    import bfs_pkg::*;
#(
    parameter int NUM_VERTICES = DEF_NUM_VERTICES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire bfs_in_t  cmd_in,
    input  wire bfs_ctl_t ctl,
    output bfs_sts_t      sts,
    output bfs_out_t      result_data
);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int QW  = $clog2(NUM_VERTICES + 1);
    localparam int XW  = $clog2(NUM_VERTICES);

    bfs_in_t          cmd_reg;
    logic [ECW-1:0]   edge_count_reg;
    logic [ECW-1:0]   eidx_reg;
    logic [QW-1:0]    qhead_reg, qtail_reg;
    logic [NUM_VERTICES-1:0] visited_reg;
    logic [VW-1:0]    root_reg;
    logic [VW-1:0]    cur_reg;       // popped vertex or path vertex
    logic [VW-1:0]    cur_dist_reg;

    logic [VW-1:0] efrom_q, eto_q, par_q, dist_q, queue_q;
    logic [EAW-1:0] e_waddr, e_raddr;
    logic           tree_we;
    logic [XW-1:0]  tree_waddr, tree_raddr;
    logic [VW-1:0]  par_wdata, dist_wdata;
    logic           q_we;
    logic [XW-1:0]  q_waddr, q_raddr;
    logic [VW-1:0]  q_wdata;
    logic           take_w;

    assign e_waddr = edge_count_reg[EAW-1:0];
    assign e_raddr = eidx_reg[EAW-1:0];

    bfs_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_efrom (
        .clk, .we(ctl.add_edge), .waddr(e_waddr), .wdata(cmd_reg.first_vertex),
        .raddr(e_raddr), .rdata(efrom_q));
    bfs_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_eto (
        .clk, .we(ctl.add_edge), .waddr(e_waddr), .wdata(cmd_reg.second_vertex),
        .raddr(e_raddr), .rdata(eto_q));
    bfs_ram #(.WIDTH(VW), .DEPTH(NUM_VERTICES)) u_par (
        .clk, .we(tree_we), .waddr(tree_waddr), .wdata(par_wdata),
        .raddr(tree_raddr), .rdata(par_q));
    bfs_ram #(.WIDTH(VW), .DEPTH(NUM_VERTICES)) u_dist (
        .clk, .we(tree_we), .waddr(tree_waddr), .wdata(dist_wdata),
        .raddr(tree_raddr), .rdata(dist_q));
    bfs_ram #(.WIDTH(VW), .DEPTH(NUM_VERTICES)) u_queue (
        .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(queue_q));

    // Edge hit: source matches popped vertex, target new, queue has room.
    assign take_w = ctl.scan_visit && (efrom_q == cur_reg)
                    && ({{(32-VW){1'b0}}, eto_q} < NUM_VERTICES)
                    && !visited_reg[eto_q[XW-1:0]]
                    && ({{(32-QW){1'b0}}, qtail_reg} < NUM_VERTICES);

    always_comb
    begin
        tree_we    = 1'b0;
        tree_waddr = cmd_reg.first_vertex[XW-1:0];
        par_wdata  = cmd_reg.first_vertex;
        dist_wdata = '0;
        q_we       = 1'b0;
        q_waddr    = qtail_reg[XW-1:0];
        q_wdata    = cmd_reg.first_vertex;
        if (ctl.seed_root)
        begin
            tree_we = 1'b1;
            q_we    = 1'b1;
        end
        else if (take_w)
        begin
            tree_we    = 1'b1;
            tree_waddr = eto_q[XW-1:0];
            par_wdata  = cur_reg;
            dist_wdata = cur_dist_reg + VW'(1);
            q_we       = 1'b1;
            q_wdata    = eto_q;
        end
    end

    assign q_raddr = qhead_reg[XW-1:0];
    // Popped vertex address in BFS, walk vertex in path mode.
    assign tree_raddr = ctl.pop ? queue_q[XW-1:0] : cur_reg[XW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg <= '0;
            visited_reg    <= '0;
            qhead_reg      <= '0;
            qtail_reg      <= '0;
            root_reg       <= '0;
        end
        else
        begin
            if (ctl.clear_graph)
            begin
                edge_count_reg <= '0;
            end
            else if (ctl.add_edge)
            begin
                edge_count_reg <= edge_count_reg + ECW'(1);
            end
            if (ctl.clear_marks || ctl.clear_graph)
            begin
                visited_reg <= '0;
                qhead_reg   <= '0;
                qtail_reg   <= '0;
            end
            else if (ctl.seed_root)
            begin
                visited_reg[cmd_reg.first_vertex[XW-1:0]] <= 1'b1;
                qtail_reg <= qtail_reg + QW'(1);
                root_reg  <= cmd_reg.first_vertex;
            end
            else
            begin
                if (take_w)
                begin
                    visited_reg[eto_q[XW-1:0]] <= 1'b1;
                    qtail_reg <= qtail_reg + QW'(1);
                end
                if (ctl.scan_start)
                begin
                    qhead_reg <= qhead_reg + QW'(1);
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctl.load_cmd)
        begin
            cmd_reg <= cmd_in;
        end
        if (ctl.scan_start)
        begin
            eidx_reg <= '0;
        end
        else if (ctl.scan_read)
        begin
            eidx_reg <= eidx_reg + ECW'(1);
        end
        if (ctl.pop)
        begin
            cur_reg <= queue_q;
        end
        else if (ctl.path_init)
        begin
            cur_reg <= cmd_reg.second_vertex;
        end
        else if (ctl.path_step)
        begin
            cur_reg <= par_q;
        end
        if (ctl.scan_start)
        begin
            cur_dist_reg <= dist_q;
        end
    end

    assign sts.edge_ok = ({{(32-VW){1'b0}}, cmd_reg.first_vertex} < NUM_VERTICES)
                      && ({{(32-VW){1'b0}}, cmd_reg.second_vertex} < NUM_VERTICES);
    assign sts.store_full = ({{(32-ECW){1'b0}}, edge_count_reg} >= MAX_EDGES);
    assign sts.root_ok = ({{(32-VW){1'b0}}, cmd_reg.first_vertex} < NUM_VERTICES);
    assign sts.queue_empty = (qhead_reg == qtail_reg);
    assign sts.scan_done = (eidx_reg == edge_count_reg);
    assign sts.end_ok = ({{(32-VW){1'b0}}, cmd_reg.second_vertex} < NUM_VERTICES)
                     && visited_reg[cmd_reg.second_vertex[XW-1:0]];
    assign sts.path_final = (cur_reg == cmd_reg.first_vertex) || (cur_reg == root_reg);

    always_comb
    begin
        result_data.vertex   = cur_reg;
        result_data.distance = '0;
        result_data.status   = ST_OK;
        result_data.last     = 1'b0;
        if (ctl.emit_full)
        begin
            result_data.vertex = cmd_reg.first_vertex;
            result_data.status = ST_FULL;
            result_data.last   = 1'b1;
        end
        else if (ctl.emit_nopath_end)
        begin
            result_data.vertex = cmd_reg.second_vertex;
            result_data.status = ST_NOPATH;
            result_data.last   = 1'b1;
        end
        else if (ctl.emit_bfs)
        begin
            result_data.distance = cur_dist_reg;
            result_data.last     = (qhead_reg == qtail_reg);
        end
        else
        begin
            result_data.distance = dist_q;
            result_data.last     = sts.path_final;
            result_data.status   = (cur_reg != cmd_reg.first_vertex && cur_reg == root_reg)
                                   ? ST_NOPATH : ST_OK;
        end
    end
endmodule
`default_nettype wire

// ----- design/bfs_ctrl.sv -----
`default_nettype none
module bfs_ctrl
    import bfs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic [1:0] command,
    input  wire bfs_sts_t sts,
    output bfs_ctl_t      ctl,
    output logic          busy,
    output logic          strobe
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_POP    = 4'd2;
    localparam logic [3:0] S_POPW   = 4'd3;
    localparam logic [3:0] S_LATCH  = 4'd4;
    localparam logic [3:0] S_SREAD  = 4'd5;
    localparam logic [3:0] S_SVIS   = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;
    localparam logic [3:0] S_PREAD  = 4'd8;
    localparam logic [3:0] S_PSTEP  = 4'd9;
    localparam logic [3:0] S_SEED   = 4'd10;
    localparam logic [3:0] S_LAST   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [1:0] op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= CMD_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && start)
            begin
                op_reg <= command;
            end
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        ctl        = '0;
        strobe     = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                ctl.load_cmd = 1'b1;
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (op_reg)
                    CMD_CLEAR: ctl.clear_graph = 1'b1;
                    CMD_ADD:
                    begin
                        if (sts.edge_ok && sts.store_full)
                        begin
                            ctl.emit_full = 1'b1;
                            strobe = 1'b1;
                        end
                        else if (sts.edge_ok)
                        begin
                            ctl.add_edge = 1'b1;
                        end
                    end
                    CMD_BFS:
                    begin
                        ctl.clear_marks = 1'b1;
                        if (sts.root_ok)
                        begin
                            state_next = S_SEED;
                        end
                    end
                    default:
                    begin
                        if (!sts.end_ok)
                        begin
                            ctl.emit_nopath_end = 1'b1;
                            strobe = 1'b1;
                        end
                        else
                        begin
                            ctl.path_init = 1'b1;
                            state_next = S_PREAD;
                        end
                    end
                endcase
            end
            S_SEED:
            begin
                ctl.seed_root = 1'b1;
                state_next = S_POP;
            end
            S_POP:
            begin
                // queue read data registered this edge
                state_next = S_POPW;
            end
            S_POPW:
            begin
                ctl.pop = 1'b1;
                state_next = S_LATCH;
            end
            S_LATCH:
            begin
                ctl.scan_start = 1'b1;
                state_next = S_SREAD;
            end
            S_SREAD:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    ctl.scan_read = 1'b1;
                    state_next = S_SVIS;
                end
            end
            S_SVIS:
            begin
                ctl.scan_visit = 1'b1;
                state_next = S_SREAD;
            end
            S_EMIT:
            begin
                ctl.emit_bfs = 1'b1;
                strobe = 1'b1;
                state_next = sts.queue_empty ? S_IDLE : S_POP;
            end
            S_PREAD:
            begin
                state_next = S_PSTEP;
            end
            S_PSTEP:
            begin
                strobe = 1'b1;
                if (sts.path_final)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.path_step = 1'b1;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                // parent register loads; reissue read
                state_next = S_PREAD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_start_ignored_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && start) |=> (state_reg != S_DECODE || $past(state_reg) == S_IDLE))
        else $error("item taken while busy");
    a_one_ctl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.add_edge, ctl.seed_root, ctl.emit_full, ctl.path_init}))
        else $error("conflicting commands");
    a_emit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit_bfs |-> strobe)
        else $error("bfs result without strobe");
endmodule
`default_nettype wire

// ----- design/bfs_tree_and_path.sv -----
// Channel  | Ports                          | Handshake
// command  | start, busy, cmd (bfs_in_t)    | taken when start & !busy
// result   | result_valid, result           | one cycle, no backpressure
// Clear, add edge, failed path and out-of-range root take only accept and decode.
// BFS: accept, decode, seed, then per dequeued vertex pop, wait, latch, a read and
// a visit for every stored edge, a done check and emit (each edge once per vertex).
// Path: accept, decode; per vertex read (registered), emit, load parent unless last.
// rst_n clears edge count, visit marks and queue pointers; no clearing pass.
// Results cannot be stalled; each is valid for one cycle.
`default_nettype none
module bfs_tree_and_path
    import bfs_pkg::*;
#(
    parameter int NUM_VERTICES = DEF_NUM_VERTICES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire bfs_in_t cmd,
    output logic         result_valid,
    output bfs_out_t     result
);
    bfs_ctl_t ctl;
    bfs_sts_t sts;

    bfs_ctrl u_ctrl (
        .clk, .rst_n, .start, .command(cmd.command), .sts, .ctl, .busy,
        .strobe(result_valid));

    bfs_datapath #(.NUM_VERTICES(NUM_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
        .clk, .rst_n, .cmd_in(cmd), .ctl, .sts, .result_data(result));
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import bfs_pkg::*;

    localparam int NV = DEF_NUM_VERTICES;
    localparam int NE = DEF_MAX_EDGES;
    localparam int STALL_LIMIT = 200000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    bfs_in_t  cmd;
    logic     result_valid;
    bfs_out_t result;

    bfs_tree_and_path dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .result_valid(result_valid), .result(result)
    );

    // graph predictor state
    logic [5:0] g_from [NE];
    logic [5:0] g_to [NE];
    int         g_count;
    bit         g_seen [NV];
    logic [5:0] g_parent [NV];
    logic [5:0] g_hops [NV];
    logic [5:0] g_root;

    bfs_in_t  pending_items [$];
    bfs_out_t expected_results [$];
    int       error_count;
    int       results_seen;
    int       items_sent;
    int       items_queued;
    int       idle_pct;
    int       quiet_cycles;

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic enqueue_item(input bfs_in_t it);
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endtask

    task automatic expect_result(input bfs_out_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    function automatic bfs_out_t mk(logic [5:0] v, logic [5:0] d, logic [1:0] s, logic l);
        bfs_out_t r;
        r.vertex = v;
        r.distance = d;
        r.status = s;
        r.last = l;
        return r;
    endfunction

    task automatic predict_graph(input bfs_in_t it);
        logic [5:0] q [$];
        logic [5:0] v;
        int tail;
        int n;
        case (it.command)
            CMD_CLEAR:
            begin
                g_count = 0;
                foreach (g_seen[i]) g_seen[i] = 0;
            end
            CMD_ADD:
            begin
                if (g_count >= NE)
                    expect_result(mk(it.first_vertex, 6'd0, ST_FULL, 1'b1));
                else
                begin
                    g_from[g_count] = it.first_vertex;
                    g_to[g_count] = it.second_vertex;
                    g_count++;
                end
            end
            CMD_BFS:
            begin
                foreach (g_seen[i]) g_seen[i] = 0;
                g_root = it.first_vertex;
                g_seen[g_root] = 1;
                g_hops[g_root] = 0;
                g_parent[g_root] = g_root;
                q.insert(q.size(), g_root);
                tail = 1;
                while (q.size() > 0)
                begin
                    v = q.pop_front();
                    for (int e = 0; e < g_count; e++)
                    begin
                        if (g_from[e] == v && !g_seen[g_to[e]] && tail < NV)
                        begin
                            g_seen[g_to[e]] = 1;
                            g_parent[g_to[e]] = v;
                            g_hops[g_to[e]] = g_hops[v] + 6'd1;
                            q.insert(q.size(), g_to[e]);
                            tail++;
                        end
                    end
                    expect_result(mk(v, g_hops[v], ST_OK, q.size() == 0));
                end
            end
            default:
            begin
                v = it.second_vertex;
                if (!g_seen[v])
                    expect_result(mk(v, 6'd0, ST_NOPATH, 1'b1));
                else
                begin
                    n = 0;
                    while (1)
                    begin
                        if (v == it.first_vertex)
                        begin
                            expect_result(mk(v, g_hops[v], ST_OK, 1'b1));
                            break;
                        end
                        if (v == g_root || n >= NV - 1)
                        begin
                            expect_result(mk(v, g_hops[v], ST_NOPATH, 1'b1));
                            break;
                        end
                        expect_result(mk(v, g_hops[v], ST_OK, 1'b0));
                        n++;
                        v = g_parent[v];
                    end
                end
            end
        endcase
    endtask

    function automatic bfs_in_t item(int c, int a, int b);
        bfs_in_t it;
        it.command = 2'(c);
        it.first_vertex = 6'(a);
        it.second_vertex = 6'(b);
        return it;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 0;
        else if (start && !busy)
        begin
            // idle again: present the head item or pause
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
                cmd <= pending_items[0];
            else
                start <= 0;
        end
        else if (!start && pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
        begin
            cmd <= pending_items[0];
            start <= 1;
        end
    end

    // monitor: accept items and results at rising edges
    always @(posedge clk)
    begin
        bfs_out_t exp_r;
        if (rst_n)
        begin
            quiet_cycles <= ((start && !busy) || result_valid) ? 0 : quiet_cycles + 1;
            if (start && !busy)
            begin
                predict_graph(cmd);
                void'(pending_items.pop_front());
                items_sent <= items_sent + 1;
            end
            if (result_valid)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result.vertex !== exp_r.vertex)
                        report_mismatch($sformatf("vertex %0d exp %0d", result.vertex, exp_r.vertex));
                    if (result.distance !== exp_r.distance)
                        report_mismatch($sformatf("distance %0d exp %0d", result.distance,
                            exp_r.distance));
                    if (result.status !== exp_r.status)
                        report_mismatch($sformatf("status %0d exp %0d", result.status, exp_r.status));
                    if (result.last !== exp_r.last)
                        report_mismatch($sformatf("last %0d exp %0d", result.last, exp_r.last));
                end
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout waiting for handshake");
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic add_random_graph(input int nv, input int ne);
        enqueue_item(item(CMD_CLEAR, $urandom, $urandom));
        for (int i = 0; i < ne; i++)
            enqueue_item(item(CMD_ADD, $urandom_range(nv - 1), $urandom_range(nv - 1)));
    endtask

    task automatic wait_drain();
        while (pending_items.size() > 0 || start)
            @(posedge clk);
    endtask

    initial
    begin
        int nv;
        int base;
        start = 0;
        cmd = '0;
        rst_n = 0;
        error_count = 0;
        results_seen = 0;
        items_sent = 0;
        items_queued = 0;
        quiet_cycles = 0;
        g_count = 0;
        g_root = 0;
        foreach (g_seen[i]) g_seen[i] = 0;
        idle_pct = 33;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: path before any search, small chain, extremes, full store
        enqueue_item(item(CMD_PATH, 0, 63));
        enqueue_item(item(CMD_ADD, 0, 63));
        enqueue_item(item(CMD_ADD, 63, 5));
        enqueue_item(item(CMD_ADD, 5, 0));
        enqueue_item(item(CMD_ADD, 63, 63));
        enqueue_item(item(CMD_BFS, 0, 0));
        enqueue_item(item(CMD_PATH, 0, 5));
        enqueue_item(item(CMD_PATH, 63, 5));
        enqueue_item(item(CMD_PATH, 7, 5));
        enqueue_item(item(CMD_PATH, 5, 5));
        enqueue_item(item(CMD_PATH, 0, 40));
        enqueue_item(item(CMD_BFS, 63, 0));
        enqueue_item(item(CMD_BFS, 42, 0));
        enqueue_item(item(CMD_CLEAR, 63, 63));
        enqueue_item(item(CMD_PATH, 0, 5));
        enqueue_item(item(CMD_BFS, 0, 21));
        enqueue_item(item(CMD_PATH, 42, 0));
        for (int i = 0; i < NE; i++)
            enqueue_item(item(CMD_ADD, i % 64, (i * 7 + 1) % 64));
        enqueue_item(item(CMD_ADD, 63, 42));
        enqueue_item(item(CMD_BFS, 0, 0));
        enqueue_item(item(CMD_PATH, 0, 63));
        wait_drain();

        // random: sessions of small graphs, then search and walk, now and then a random item
        base = items_queued;
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 33 : (phase == 1) ? 85 : 0;
            while (items_queued < base + (phase + 1) * 75)
            begin
                nv = $urandom_range(3) == 0 ? 64 : $urandom_range(2, 12);
                add_random_graph(nv, $urandom_range(1, 20));
                for (int k = 0; k < $urandom_range(1, 4); k++)
                begin
                    enqueue_item(item(CMD_BFS, $urandom_range(nv - 1), $urandom));
                    for (int j = 0; j < $urandom_range(1, 5); j++)
                        enqueue_item(item(CMD_PATH,
                            $urandom_range(nv - 1), $urandom_range(nv - 1)));
                end
                if ($urandom_range(3) == 0)
                    enqueue_item(item($urandom, $urandom, $urandom));
                wait_drain();
            end
        end
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("items accepted: %0d, results checked: %0d", items_sent, results_seen);
        $display("covered clear, edge load, full store, searches and path walks");
        if (error_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
design/bfs_pkg.sv
design/bfs_ram.sv
design/bfs_datapath.sv
design/bfs_ctrl.sv
design/bfs_tree_and_path.sv
test/tb_top.sv
